>>> sv/lkr_pkg.sv
// ----------------------------------------------------------------------------
// lkr_pkg - shared types and constants of the LRU-K frame replacer
// Command and status codes, sequencer states and the list control struct.
// ----------------------------------------------------------------------------
package lkr_pkg;

  localparam int FRAME_W   = 4;
  localparam int FRAME_CNT = 1 << FRAME_W;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int K_W       = 4;

  localparam logic [K_W-1:0] K_RESET = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACCESS   = 2'd0,
    CMD_SET_FLAG = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_EVICT    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_PINNED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIND,
    ST_PUSH,
    ST_EVICT,
    ST_DONE
  } state_e;

  // One list operation per cycle: append a frame, or drop the entry at pos.
  typedef struct packed {
    logic               push;
    logic               drop;
    logic [FRAME_W-1:0] pos;
    logic [FRAME_W-1:0] frame;
  } list_ctrl_t;

endpackage

>>> sv/lkr_list.sv
// ----------------------------------------------------------------------------
// lkr_list - ordered frame list
// Appends at the tail, closes the gap on a drop, one read port by position.
// ----------------------------------------------------------------------------
module lkr_list import lkr_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  list_ctrl_t         ctrl_i,
  input  logic [IW-1:0]      rd_idx_i,
  output logic [FRAME_W-1:0] rd_frame_o,
  output logic [LW-1:0]      len_o
);

  logic [FRAME_W-1:0] order_q [DEPTH];
  logic [LW-1:0]      len_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (len_q < LW'(DEPTH))) begin
      order_q[len_q[IW-1:0]] <= ctrl_i.frame;
    end
    if (ctrl_i.drop) begin
      // shift everything behind the dropped slot one place forward
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (j >= int'(ctrl_i.pos)) begin
          order_q[j] <= order_q[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (ctrl_i.push && (len_q < LW'(DEPTH))) begin
      len_q <= len_q + LW'(1);
    end else if (ctrl_i.drop && (len_q != '0)) begin
      len_q <= len_q - LW'(1);
    end
  end

  assign rd_frame_o = order_q[rd_idx_i];
  assign len_o      = len_q;

endmodule

>>> sv/lru_k_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer - LRU-K buffer frame replacer
// Tracks access counts and evictable flags, keeps a history list and a cache
// list, and picks eviction victims by stepping one compare over list slots.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------
//  in       | in  | in_valid_i / in_stall_o | command_i, frame_i, evictable_flag_i
//  out      | out | out_valid_o/out_stall_i | status_o, victim_frame_o,
//           |     |                         | evictable_count_o
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (k threshold)
//
//  Flag updates and simple accesses: result registered after EXEC and DONE.
//  Relinking an access or removing a frame adds a FIND scan up to its list slot
//  (plus PUSH to append), set by the single list read port and compare stepped
//  per slot. Evict adds an EVICT scan over the history list, then the cache list.
//  One transaction at a time; in_stall_o is high from accept until the result
//  moves into the output register, which may still hold an earlier result.
//  Asynchronous active-low reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer import lkr_pkg::*; #(
  parameter int FRAME_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [K_W-1:0]      cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [FRAME_W-1:0]  frame_i,
  input  logic                evictable_flag_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [FRAME_W-1:0]  victim_frame_o,
  output logic [COUNT_W-1:0]  evictable_count_o
);

  // only frames addressable by the frame field can ever be tracked
  localparam int NT = (FRAME_SLOTS < FRAME_CNT) ? FRAME_SLOTS : FRAME_CNT;
  localparam int IW = $clog2(NT);
  localparam int LW = $clog2(NT + 1);

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               flag_q, flag_d;
  logic [K_W-1:0]     k_q;
  logic [K_W-1:0]     cnt_q [NT];
  logic [K_W-1:0]     cnt_d [NT];
  logic [NT-1:0]      mark_q, mark_d;
  logic [NT-1:0]      cached_q, cached_d;
  logic [LW-1:0]      total_q, total_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic               in_cache_q, in_cache_d;
  logic               relink_q, relink_d;
  status_e            res_status_q, res_status_d;
  logic [FRAME_W-1:0] res_victim_q, res_victim_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [FRAME_W-1:0] out_victim_q, out_victim_d;
  logic [LW-1:0]      out_count_q, out_count_d;

  list_ctrl_t         hist_ctrl, cache_ctrl;
  logic [FRAME_W-1:0] hist_rd, cache_rd;
  logic [LW-1:0]      hist_len, cache_len;

  logic [IW-1:0]      fidx, vidx;
  logic               frame_ok, tracked, out_free, at_end, hit;
  logic [K_W-1:0]     k_eff, cnt_cur, cnt_next;
  logic [LW-1:0]      sel_len;
  logic [FRAME_W-1:0] sel_frame;

  lkr_list #(.DEPTH(NT)) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hist_ctrl),
    .rd_idx_i   (idx_q[IW-1:0]),
    .rd_frame_o (hist_rd),
    .len_o      (hist_len)
  );

  lkr_list #(.DEPTH(NT)) u_cache (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cache_ctrl),
    .rd_idx_i   (idx_q[IW-1:0]),
    .rd_frame_o (cache_rd),
    .len_o      (cache_len)
  );

  assign fidx      = frame_q[IW-1:0];
  assign frame_ok  = int'(frame_q) < FRAME_SLOTS;
  assign tracked   = cnt_q[fidx] != '0;
  assign k_eff     = (k_q == '0) ? K_W'(1) : k_q;
  assign cnt_cur   = cnt_q[fidx];
  assign cnt_next  = (cnt_cur < k_eff) ? cnt_cur + K_W'(1) : cnt_cur;
  assign sel_len   = in_cache_q ? cache_len : hist_len;
  assign sel_frame = in_cache_q ? cache_rd : hist_rd;
  assign vidx      = sel_frame[IW-1:0];
  assign at_end    = idx_q == sel_len;
  assign hit       = sel_frame == frame_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (cmd_q)
          CMD_ACCESS: begin
            if (frame_ok && tracked && (cached_q[fidx] || cnt_next >= k_eff)) begin
              state_d = ST_FIND;
            end
          end
          CMD_REMOVE: begin
            if (frame_ok && tracked && mark_q[fidx]) state_d = ST_FIND;
          end
          CMD_EVICT: state_d = ST_EVICT;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_FIND: begin
        if (hit) state_d = relink_q ? ST_PUSH : ST_DONE;
      end
      ST_PUSH: state_d = ST_DONE;
      ST_EVICT: begin
        if (at_end) begin
          if (in_cache_q) state_d = ST_DONE;
        end else if (mark_q[vidx]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and list control
  always_comb begin
    cmd_d        = cmd_q;
    frame_d      = frame_q;
    flag_d       = flag_q;
    cnt_d        = cnt_q;
    mark_d       = mark_q;
    cached_d     = cached_q;
    total_d      = total_q;
    idx_d        = idx_q;
    in_cache_d   = in_cache_q;
    relink_d     = relink_q;
    res_status_d = res_status_q;
    res_victim_d = res_victim_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_victim_d = out_victim_q;
    out_count_d  = out_count_q;
    hist_ctrl    = '0;
    cache_ctrl   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_e'(command_i);
          frame_d      = frame_i;
          flag_d       = evictable_flag_i;
          res_status_d = STATUS_OK;
          res_victim_d = '0;
          idx_d        = '0;
          in_cache_d   = 1'b0;
          relink_d     = 1'b0;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_ACCESS: begin
            if (frame_ok) begin
              cnt_d[fidx] = cnt_next;
              if (!tracked) begin
                cached_d[fidx] = cnt_next >= k_eff;
                if (cnt_next >= k_eff) begin
                  cache_ctrl.push  = 1'b1;
                  cache_ctrl.frame = frame_q;
                end else begin
                  hist_ctrl.push  = 1'b1;
                  hist_ctrl.frame = frame_q;
                end
              end else if (cached_q[fidx] || cnt_next >= k_eff) begin
                // unlink from the current list, then append to the cache
                in_cache_d = cached_q[fidx];
                relink_d   = 1'b1;
              end
            end
          end
          CMD_SET_FLAG: begin
            if (frame_ok && tracked) begin
              if (!mark_q[fidx] && flag_q) total_d = total_q + LW'(1);
              if (mark_q[fidx] && !flag_q && total_q != '0) total_d = total_q - LW'(1);
              mark_d[fidx] = flag_q;
            end
          end
          CMD_REMOVE: begin
            if (frame_ok && tracked) begin
              if (!mark_q[fidx]) res_status_d = STATUS_PINNED;
              else               in_cache_d   = cached_q[fidx];
            end
          end
          default: begin
          end
        endcase
      end
      ST_FIND: begin
        if (hit) begin
          if (in_cache_q) begin
            cache_ctrl.drop = 1'b1;
            cache_ctrl.pos  = FRAME_W'(idx_q);
          end else begin
            hist_ctrl.drop = 1'b1;
            hist_ctrl.pos  = FRAME_W'(idx_q);
          end
          if (relink_q) begin
            cached_d[fidx] = 1'b1;
          end else begin
            if (mark_q[fidx] && total_q != '0) total_d = total_q - LW'(1);
            cnt_d[fidx]    = '0;
            mark_d[fidx]   = 1'b0;
            cached_d[fidx] = 1'b0;
          end
        end else begin
          idx_d = idx_q + LW'(1);
        end
      end
      ST_PUSH: begin
        cache_ctrl.push  = 1'b1;
        cache_ctrl.frame = frame_q;
      end
      ST_EVICT: begin
        if (at_end) begin
          // history exhausted: move on to the cache list; cache exhausted: report empty
          if (!in_cache_q) begin
            in_cache_d = 1'b1;
            idx_d      = '0;
          end else begin
            res_status_d = STATUS_EMPTY;
          end
        end else if (mark_q[vidx]) begin
          if (in_cache_q) begin
            cache_ctrl.drop = 1'b1;
            cache_ctrl.pos  = FRAME_W'(idx_q);
          end else begin
            hist_ctrl.drop = 1'b1;
            hist_ctrl.pos  = FRAME_W'(idx_q);
          end
          if (total_q != '0) total_d = total_q - LW'(1);
          cnt_d[vidx]    = '0;
          mark_d[vidx]   = 1'b0;
          cached_d[vidx] = 1'b0;
          res_victim_d   = sel_frame;
        end else begin
          idx_d = idx_q + LW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_victim_d = res_victim_q;
          out_count_d  = total_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= K_RESET;
      mark_q      <= '0;
      cached_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      mark_q      <= mark_d;
      cached_q    <= cached_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) k_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    frame_q      <= frame_d;
    flag_q       <= flag_d;
    idx_q        <= idx_d;
    in_cache_q   <= in_cache_d;
    relink_q     <= relink_d;
    res_status_q <= res_status_d;
    res_victim_q <= res_victim_d;
    out_status_q <= out_status_d;
    out_victim_q <= out_victim_d;
    out_count_q  <= out_count_d;
  end

  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign victim_frame_o    = out_victim_q;
  assign evictable_count_o = COUNT_W'(out_count_q);

  a_total_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mark_q) == int'(total_q))
    else $error("evictable total out of step with flags");

  a_lists_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(hist_len) + int'(cache_len) <= NT)
    else $error("list lengths exceed frame count");

  a_find_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIND |-> idx_q < sel_len)
    else $error("tracked frame missing from its list");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> victim_frame_o == '0 && evictable_count_o == '0)
    else $error("nothing-evictable result with victim or count");

  a_no_push_and_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hist_ctrl.push && hist_ctrl.drop) && !(cache_ctrl.push && cache_ctrl.drop))
    else $error("push and drop on one list in the same cycle");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking testbench of the LRU-K frame replacer
// Drives commands through the valid/stall input channel, predicts each result
// with a behavioral copy of the history and cache lists, and compares every
// result transaction field by field. Covers all commands, threshold extremes,
// threshold changes with frames still tracked, random idling and a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import lkr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES       = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 5000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    status_e              status;
    logic [FRAME_W-1:0]   victim;
    logic [COUNT_W-1:0]   count;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [K_W-1:0]      cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i        = '0;
  logic [FRAME_W-1:0]  frame_i          = '0;
  logic                evictable_flag_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [FRAME_W-1:0]  victim_frame_o;
  logic [COUNT_W-1:0]  evictable_count_o;

  // Behavioral copy of the replacer state
  logic [K_W-1:0]     threshold = K_RESET;
  logic [K_W-1:0]     access_cnt [FRAMES];
  logic               evictable  [FRAMES];
  logic               in_cache   [FRAMES];
  logic [FRAME_W-1:0] history_list[$];
  logic [FRAME_W-1:0] cache_list[$];
  int                 evictable_total = 0;

  outcome_t pending_outcomes[$];
  outcome_t head_outcome;
  int       fail_cnt   = 0;
  int       stuck_cnt  = 0;
  bit       idle_en    = 1'b1;
  bit       stall_en   = 1'b1;
  bit       hold_req   = 1'b0;
  int       hold_left  = 0;

  lru_k_frame_replacer #(.FRAME_SLOTS(FRAMES)) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .frame_i          (frame_i),
    .evictable_flag_i (evictable_flag_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .victim_frame_o   (victim_frame_o),
    .evictable_count_o(evictable_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      access_cnt[i] = '0;
      evictable[i]  = 1'b0;
      in_cache[i]   = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void unlink_frame(logic [FRAME_W-1:0] f);
    int i;
    if (in_cache[f]) begin
      for (i = 0; i < cache_list.size(); i++)
        if (cache_list[i] == f) begin
          cache_list.delete(i);
          break;
        end
    end else begin
      for (i = 0; i < history_list.size(); i++)
        if (history_list[i] == f) begin
          history_list.delete(i);
          break;
        end
    end
  endfunction

  function automatic void forget_frame(logic [FRAME_W-1:0] f);
    unlink_frame(f);
    if (evictable[f] && evictable_total > 0) evictable_total--;
    access_cnt[f] = '0;
    evictable[f]  = 1'b0;
    in_cache[f]   = 1'b0;
  endfunction

  function automatic outcome_t replacer_predict(cmd_e cmd, logic [FRAME_W-1:0] f,
                                                logic flag);
    outcome_t o;
    int       k;
    int       c;
    int       v;
    int       i;
    o.status = STATUS_OK;
    o.victim = '0;
    k = (threshold == 0) ? 1 : int'(threshold);
    case (cmd)
      CMD_ACCESS: begin
        c = access_cnt[f];
        if (c < k) c++;
        if (access_cnt[f] == 0) begin
          in_cache[f] = (c >= k);
          if (c >= k) cache_list.push_back(f);
          else history_list.push_back(f);
        end else if (in_cache[f] || c >= k) begin
          // relink to the most recent end of the cache list
          unlink_frame(f);
          in_cache[f] = 1'b1;
          cache_list.push_back(f);
        end
        access_cnt[f] = c[K_W-1:0];
      end
      CMD_SET_FLAG: begin
        if (access_cnt[f] != 0) begin
          if (!evictable[f] && flag) evictable_total++;
          if (evictable[f] && !flag && evictable_total > 0) evictable_total--;
          evictable[f] = flag;
        end
      end
      CMD_REMOVE: begin
        if (access_cnt[f] != 0) begin
          if (!evictable[f]) o.status = STATUS_PINNED;
          else forget_frame(f);
        end
      end
      default: begin
        v = -1;
        for (i = 0; i < history_list.size() && v < 0; i++)
          if (evictable[history_list[i]]) v = history_list[i];
        for (i = 0; i < cache_list.size() && v < 0; i++)
          if (evictable[cache_list[i]]) v = cache_list[i];
        if (v < 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          forget_frame(v[FRAME_W-1:0]);
          o.victim = v[FRAME_W-1:0];
        end
      end
    endcase
    o.count = evictable_total[COUNT_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_item(cmd_e cmd, logic [FRAME_W-1:0] f, logic flag);
    if (idle_en && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    frame_i          <= f;
    evictable_flag_i <= flag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_outcomes.push_back(replacer_predict(cmd, f, flag));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [K_W-1:0] k);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    threshold = k;
  endtask

  // Mostly hot frames so accesses repeat and reach the cache list
  task automatic run_traffic(int n, int hot_max, int evict_pct);
    cmd_e               cmd;
    logic [FRAME_W-1:0] f;
    int                 r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 65) f = FRAME_W'($urandom_range(hot_max));
      else f = FRAME_W'($urandom_range(FRAMES - 1));
      r = $urandom_range(99);
      if ($urandom_range(99) < evict_pct) cmd = CMD_EVICT;
      else if (r < 55) cmd = CMD_ACCESS;
      else if (r < 85) cmd = CMD_SET_FLAG;
      else cmd = CMD_REMOVE;
      send_item(cmd, f, $urandom_range(99) < 75);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_commands();
    send_item(CMD_EVICT, 4'd0, 1'b0);     // nothing evictable
    send_item(CMD_REMOVE, 4'd5, 1'b0);    // untracked frame
    send_item(CMD_SET_FLAG, 4'd5, 1'b1);  // untracked frame
    send_item(CMD_ACCESS, 4'd0, 1'b0);
    send_item(CMD_ACCESS, 4'd15, 1'b0);
    send_item(CMD_REMOVE, 4'd0, 1'b0);    // refused, not evictable
    send_item(CMD_SET_FLAG, 4'd0, 1'b1);
    send_item(CMD_SET_FLAG, 4'd15, 1'b1);
    send_item(CMD_ACCESS, 4'd15, 1'b0);   // moves to cache
    send_item(CMD_ACCESS, 4'd7, 1'b0);
    send_item(CMD_SET_FLAG, 4'd7, 1'b1);
    send_item(CMD_EVICT, 4'd0, 1'b0);     // oldest history frame
    send_item(CMD_EVICT, 4'd0, 1'b0);
    send_item(CMD_EVICT, 4'd0, 1'b0);     // cache frame
    send_item(CMD_EVICT, 4'd0, 1'b0);
    send_item(CMD_ACCESS, 4'd10, 1'b0);
    send_item(CMD_ACCESS, 4'd10, 1'b0);
    send_item(CMD_ACCESS, 4'd10, 1'b0);   // saturated count
    send_item(CMD_SET_FLAG, 4'd10, 1'b1);
    send_item(CMD_SET_FLAG, 4'd10, 1'b0);
    send_item(CMD_SET_FLAG, 4'd10, 1'b1);
    send_item(CMD_REMOVE, 4'd10, 1'b1);
  endtask

  task automatic test_threshold_one();
    write_threshold(4'd1);
    run_traffic(90, 7, 20);
    write_threshold(4'd0);  // acts as one
    run_traffic(80, 7, 20);
  endtask

  task automatic test_saturation();
    write_threshold(4'd15);
    run_traffic(90, 1, 8);
  endtask

  task automatic test_mixed_traffic();
    write_threshold(4'd3);
    run_traffic(90, 5, 20);
    write_threshold(4'd2);
    run_traffic(90, 5, 20);
  endtask

  task automatic test_burst_no_idle();
    write_threshold(K_W'($urandom_range(4, 14)));
    idle_en  = 1'b0;
    stall_en = 1'b0;
    run_traffic(80, 3, 15);
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  task automatic test_backpressure();
    write_threshold(4'd2);
    idle_en  = 1'b0;
    hold_req = 1'b1;
    run_traffic(20, 5, 20);
    idle_en  = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_commands();
    test_threshold_one();
    test_saturation();
    test_mixed_traffic();
    test_burst_no_idle();
    test_backpressure();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= stall_en && ($urandom_range(99) < 34);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT)
          $display("unexpected result: status %0d victim %0d count %0d",
                   status_o, victim_frame_o, evictable_count_o);
      end else begin
        head_outcome = pending_outcomes.pop_front();
        if (status_o !== head_outcome.status || victim_frame_o !== head_outcome.victim ||
            evictable_count_o !== head_outcome.count) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("mismatch: expected status %0d victim %0d count %0d, got %0d %0d %0d",
                     head_outcome.status, head_outcome.victim, head_outcome.count,
                     status_o, victim_frame_o, evictable_count_o);
        end
      end
    end
  end

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cnt <= 0;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
      if (stuck_cnt >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

>>> files.f
sv/lkr_pkg.sv
sv/lkr_list.sv
sv/lru_k_frame_replacer.sv
tb/tb.sv
